// ===== sv/brfq_pkg.sv =====
// Shared types, codes and sizes for the bounded request FIFO.
// No dependencies; brfq_ctrl and the top level use this package.
package brfq_pkg;

    // Built depth of the entry store
    localparam int DEPTH = 16;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    // Field widths
    localparam int ACT_W    = 2;
    localparam int FRAME_W  = 32;
    localparam int DATA_W   = 64;
    localparam int STATUS_W = 3;
    localparam int POL_W    = 2;
    localparam int CAP_W    = 5;
    localparam int CFG_A_W  = 2;
    localparam int CFG_D_W  = 5;
    localparam int CMP_W    = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int ENTRY_W  = FRAME_W + DATA_W;

    // Stream widths
    localparam int IN_USED  = ACT_W + FRAME_W + DATA_W;
    localparam int IN_W     = ((IN_USED + 7) / 8) * 8;
    localparam int OUT_USED = STATUS_W + 1 + FRAME_W + FRAME_W + DATA_W + CAP_W + 1;
    localparam int OUT_W    = ((OUT_USED + 7) / 8) * 8;

    // Actions
    localparam logic [ACT_W-1:0] ACT_PUSH = 2'd0;
    localparam logic [ACT_W-1:0] ACT_POP  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_SHUT = 2'd2;

    // Overflow policies
    localparam logic [POL_W-1:0] POL_BLOCK  = 2'd0;
    localparam logic [POL_W-1:0] POL_REJECT = 2'd1;
    localparam logic [POL_W-1:0] POL_DROP   = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_ACCEPTED      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ACCEPTED_DROP = 3'd1;
    localparam logic [STATUS_W-1:0] ST_REJECTED      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_RETRY         = 3'd3;
    localparam logic [STATUS_W-1:0] ST_SHUTDOWN      = 3'd4;
    localparam logic [STATUS_W-1:0] ST_POPPED        = 3'd5;
    localparam logic [STATUS_W-1:0] ST_EMPTY         = 3'd6;

    // Configuration register indexes
    localparam logic [CFG_A_W-1:0] REG_POLICY   = 2'd0;
    localparam logic [CFG_A_W-1:0] REG_CAPACITY = 2'd1;

    localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd16;

    // Entry store access for one transaction
    typedef struct packed {
        logic               we;
        logic [PTR_W-1:0]   waddr;
        logic [ENTRY_W-1:0] wdata;
        logic               re;
        logic [PTR_W-1:0]   raddr;
    } mem_req_t;

    // Outcome of one transaction, held until the read data returns
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                dropped;
        logic                popped;
        logic [CAP_W-1:0]    occupancy;
        logic                shut;
    } meta_t;

endpackage

// ===== sv/brfq_ram.sv =====
// Generic single-port-write, single-port-read synchronous RAM, read-first.
// No dependencies.
module brfq_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/brfq_ctrl.sv =====
// Queue control: pointers, count, shutdown flag, policy registers and the
// per-transaction decision. Depends on brfq_pkg.
module brfq_ctrl (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [brfq_pkg::CFG_A_W-1:0]    cfg_addr,
    input  logic [brfq_pkg::CFG_D_W-1:0]    cfg_wdata,
    input  logic                            accept,
    input  logic [brfq_pkg::ACT_W-1:0]      action,
    input  logic [brfq_pkg::FRAME_W-1:0]    req_frame,
    input  logic [brfq_pkg::DATA_W-1:0]     request_data,
    output brfq_pkg::mem_req_t              mem_req,
    output brfq_pkg::meta_t                 meta
);

    logic [brfq_pkg::PTR_W-1:0]  head_reg, head_next;
    logic [brfq_pkg::PTR_W-1:0]  tail_reg, tail_next;
    logic [brfq_pkg::CNT_W-1:0]  count_reg, count_next;
    logic                        shut_reg, shut_next;
    logic [brfq_pkg::POL_W-1:0]  policy_reg;
    logic [brfq_pkg::CAP_W-1:0]  capacity_reg;

    logic [brfq_pkg::CMP_W-1:0]  eff_cap;
    logic                        full;
    logic                        push_ok;
    logic                        drop;
    logic                        pop;
    logic                        take;
    logic [brfq_pkg::STATUS_W-1:0] status;

    function automatic logic [brfq_pkg::PTR_W-1:0] next_ptr(
        input logic [brfq_pkg::PTR_W-1:0] p
    );
        if (p == brfq_pkg::PTR_W'(brfq_pkg::DEPTH - 1))
        begin
            return '0;
        end
        return p + brfq_pkg::PTR_W'(1);
    endfunction

    // Clamp capacity to 1..DEPTH
    always_comb
    begin
        if (capacity_reg == '0)
        begin
            eff_cap = brfq_pkg::CMP_W'(1);
        end
        else if (brfq_pkg::CMP_W'(capacity_reg) > brfq_pkg::CMP_W'(brfq_pkg::DEPTH))
        begin
            eff_cap = brfq_pkg::CMP_W'(brfq_pkg::DEPTH);
        end
        else
        begin
            eff_cap = brfq_pkg::CMP_W'(capacity_reg);
        end
    end

    assign full = brfq_pkg::CMP_W'(count_reg) >= eff_cap;

    always_comb
    begin
        status    = brfq_pkg::ST_RETRY;
        push_ok   = 1'b0;
        drop      = 1'b0;
        pop       = 1'b0;
        shut_next = shut_reg;
        unique case (action)
            brfq_pkg::ACT_PUSH:
            begin
                if (shut_reg)
                begin
                    status = brfq_pkg::ST_SHUTDOWN;
                end
                else if (!full)
                begin
                    status  = brfq_pkg::ST_ACCEPTED;
                    push_ok = 1'b1;
                end
                else
                begin
                    case (policy_reg)
                        brfq_pkg::POL_BLOCK:
                        begin
                            status = brfq_pkg::ST_RETRY;
                        end
                        brfq_pkg::POL_DROP:
                        begin
                            status  = brfq_pkg::ST_ACCEPTED_DROP;
                            drop    = 1'b1;
                            push_ok = 1'b1;
                        end
                        default:
                        begin
                            status = brfq_pkg::ST_REJECTED;
                        end
                    endcase
                end
            end
            brfq_pkg::ACT_POP:
            begin
                if (count_reg == '0)
                begin
                    status = brfq_pkg::ST_EMPTY;
                end
                else
                begin
                    status = brfq_pkg::ST_POPPED;
                    pop    = 1'b1;
                end
            end
            brfq_pkg::ACT_SHUT:
            begin
                status    = brfq_pkg::ST_SHUTDOWN;
                shut_next = 1'b1;
            end
            default:
            begin
                status = brfq_pkg::ST_RETRY;
            end
        endcase
    end

    assign take       = pop | drop;
    assign head_next  = take ? next_ptr(head_reg) : head_reg;
    assign tail_next  = push_ok ? next_ptr(tail_reg) : tail_reg;
    assign count_next = count_reg + brfq_pkg::CNT_W'(push_ok) - brfq_pkg::CNT_W'(take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg     <= '0;
            tail_reg     <= '0;
            count_reg    <= '0;
            shut_reg     <= 1'b0;
            policy_reg   <= brfq_pkg::POL_BLOCK;
            capacity_reg <= brfq_pkg::CAPACITY_RESET;
        end
        else
        begin
            if (accept)
            begin
                head_reg  <= head_next;
                tail_reg  <= tail_next;
                count_reg <= count_next;
                shut_reg  <= shut_next;
            end
            if (cfg_wr_en)
            begin
                unique case (cfg_addr)
                    brfq_pkg::REG_POLICY:   policy_reg   <= cfg_wdata[brfq_pkg::POL_W-1:0];
                    brfq_pkg::REG_CAPACITY: capacity_reg <= cfg_wdata;
                    default:                ;
                endcase
            end
        end
    end

    // Read-first RAM: a drop on a full store reads the head before the tail write lands
    assign mem_req.we    = accept & push_ok;
    assign mem_req.waddr = tail_reg;
    assign mem_req.wdata = {request_data, req_frame};
    assign mem_req.re    = accept & take;
    assign mem_req.raddr = head_reg;

    assign meta.status    = status;
    assign meta.dropped   = drop;
    assign meta.popped    = pop;
    assign meta.occupancy = brfq_pkg::CAP_W'(count_next);
    assign meta.shut      = shut_next;

endmodule

// ===== sv/bounded_request_fifo_overflow_policy_unit.sv =====
// Top level of the bounded request FIFO with selectable overflow policy.
// Depends on brfq_pkg, brfq_ram and brfq_ctrl.
//
//   Channel  Direction  Contents
//   s_*      in         one action per transaction: push, pop or shutdown
//   m_*      out        one result per action: status, evicted/popped entry, occupancy
//   cfg_*    in         register writes: 0 overflow policy, 1 capacity
//
// In each transaction the decision and pointer update happen at acceptance,
// the entry store returns the head entry in the next cycle, and the
// single pending slot holds the input side until that read has landed.
// Reset (rst_n low) empties the queue, clears the shutdown flag, sets policy to
// block and capacity to 16; entry contents are not cleared.
// A stalled result waits in the output register and a second one in the skid
// register, so one further action is taken while the consumer stalls.
module bounded_request_fifo_overflow_policy_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    // Input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [1:0] action, [33:2] frame, [97:34] request_data, rest zero
    input  logic [brfq_pkg::IN_W-1:0]       s_tdata,
    // Output stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [2:0] status, [3] dropped_valid, [35:4] dropped_frame, [67:36] popped_frame,
    // [131:68] popped_data, [136:132] occupancy, [137] is_shut_down, rest zero
    output logic [brfq_pkg::OUT_W-1:0]      m_tdata,
    // Configuration
    input  logic                            cfg_wr_en,
    input  logic [brfq_pkg::CFG_A_W-1:0]    cfg_addr,
    input  logic [brfq_pkg::CFG_D_W-1:0]    cfg_wdata
);

    localparam int FR_LO = brfq_pkg::ACT_W;
    localparam int DA_LO = brfq_pkg::ACT_W + brfq_pkg::FRAME_W;

    logic                                accept;
    brfq_pkg::mem_req_t                  mem_req;
    brfq_pkg::meta_t                     meta;
    logic [brfq_pkg::ENTRY_W-1:0]        rd_entry;

    // Pending transaction waiting for its read data
    logic                                pend_reg;
    brfq_pkg::meta_t                     pend_meta_reg;

    // Output register and skid stage
    logic                                out_valid_reg;
    logic [brfq_pkg::OUT_USED-1:0]       out_data_reg;
    logic                                skid_valid_reg;
    logic [brfq_pkg::OUT_USED-1:0]       skid_data_reg;

    logic                                out_free;
    logic [brfq_pkg::FRAME_W-1:0]        rd_frame;
    logic [brfq_pkg::DATA_W-1:0]         rd_data;
    logic [brfq_pkg::OUT_USED-1:0]       result;

    // Take a new action only when nothing is in flight and the skid slot is empty
    assign s_tready = !pend_reg && !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    brfq_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .accept       (accept),
        .action       (s_tdata[brfq_pkg::ACT_W-1:0]),
        .req_frame    (s_tdata[DA_LO-1:FR_LO]),
        .request_data (s_tdata[brfq_pkg::IN_USED-1:DA_LO]),
        .mem_req      (mem_req),
        .meta         (meta)
    );

    // Frame number in the low bits of an entry, payload above it
    brfq_ram #(
        .WIDTH (brfq_pkg::ENTRY_W),
        .DEPTH (brfq_pkg::DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .re    (mem_req.re),
        .raddr (mem_req.raddr),
        .rdata (rd_entry)
    );

    assign rd_frame = rd_entry[brfq_pkg::FRAME_W-1:0];
    assign rd_data  = rd_entry[brfq_pkg::ENTRY_W-1:brfq_pkg::FRAME_W];

    // Assemble the result; fields without meaning are zero
    assign result = {
        pend_meta_reg.shut,
        pend_meta_reg.occupancy,
        pend_meta_reg.popped  ? rd_data  : {brfq_pkg::DATA_W{1'b0}},
        pend_meta_reg.popped  ? rd_frame : {brfq_pkg::FRAME_W{1'b0}},
        pend_meta_reg.dropped ? rd_frame : {brfq_pkg::FRAME_W{1'b0}},
        pend_meta_reg.dropped,
        pend_meta_reg.status
    };

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            // Advance the pending slot while the registered entry store read is in flight
            pend_reg <= accept;

            if (pend_reg)
            begin
                // Skid is empty here: accepting required it so
                if (out_free)
                begin
                    out_valid_reg <= 1'b1;
                end
                else
                begin
                    skid_valid_reg <= 1'b1;
                end
            end
            else if (skid_valid_reg && out_free)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_meta_reg <= meta;
        end
        if (pend_reg)
        begin
            if (out_free)
            begin
                out_data_reg <= result;
            end
            else
            begin
                skid_data_reg <= result;
            end
        end
        else if (skid_valid_reg && out_free)
        begin
            out_data_reg <= skid_data_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(brfq_pkg::OUT_W - brfq_pkg::OUT_USED){1'b0}}, out_data_reg};

endmodule
